@@ rtl/fmi_pkg.sv @@
package fmi_pkg;

  localparam int unsigned MaxRows   = 65536;
  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned Alphabet  = 257;
  localparam int unsigned CkptDepth = MaxBlocks * Alphabet;

  localparam int unsigned BwtAw  = $clog2(MaxRows);
  localparam int unsigned CkAw   = $clog2(CkptDepth);
  localparam int unsigned CumAw  = $clog2(Alphabet);
  localparam int unsigned SymW   = 9;
  localparam int unsigned CntW   = 17;
  localparam int unsigned AddrW  = 19;
  localparam int unsigned CfgW   = 17;
  localparam int unsigned CfgIdxW = 2;

  // commands
  localparam logic [1:0] CmdLoadBwt  = 2'd0;
  localparam logic [1:0] CmdLoadCkpt = 2'd1;
  localparam logic [1:0] CmdLoadCum  = 2'd2;
  localparam logic [1:0] CmdQuery    = 2'd3;

  // error codes
  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrPos   = 2'd1;
  localparam logic [1:0] ErrBlock = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegRowCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStep     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBlocks   = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [18:0] addr;
    logic [16:0] load_value;
    logic [7:0]  query_byte;
    logic        last;
  } req_t;

  typedef struct packed {
    logic [16:0] left;
    logic [16:0] right;
    logic [16:0] count;
    logic [1:0]  error;
  } rsp_t;

endpackage

@@ rtl/fmi_req_if.sv @@
interface fmi_req_if;
  logic          valid;
  logic          ready;
  fmi_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/fmi_rsp_if.sv @@
interface fmi_rsp_if;
  logic          valid;
  logic          ready;
  fmi_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/fmi_ram.sv @@
module fmi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/fm_index_backward_search.sv @@
// FM-index backward search. Load transactions (cmd 0..2) fill the BWT symbol
// store, the checkpoint table and the C table. Query bytes arrive last byte
// first; each narrows [left,right) with two occ lookups done one after the
// other. Each bound goes through a range check, a shift-subtract division by
// the step, the checkpoint read, a scan of the symbols from the block start up
// to the bound (the BWT memory reads one symbol per cycle), a step to close
// the scan and the final sum. A byte of an empty or failed query skips these
// steps. The byte flagged last issues one result transaction with the
// interval and error, and the input stays stalled until that result is taken.
module fm_index_backward_search (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fmi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fmi_pkg::CfgW-1:0]     cfg_data_i,
  fmi_req_if.sink                      req,
  fmi_rsp_if.source                    rsp
);
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StLoad   = 4'd1;
  localparam logic [3:0] StQuery  = 4'd2;
  localparam logic [3:0] StPos    = 4'd3;
  localparam logic [3:0] StDiv    = 4'd4;
  localparam logic [3:0] StChk    = 4'd5;
  localparam logic [3:0] StRd     = 4'd6;
  localparam logic [3:0] StScan   = 4'd7;
  localparam logic [3:0] StSum    = 4'd8;
  localparam logic [3:0] StFinish = 4'd9;
  localparam logic [3:0] StOut    = 4'd10;

  // config registers
  logic [16:0] row_count_q, step_q, blocks_q;
  logic [10:0] blocks_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q  <= '0;
      step_q       <= 17'd128;
      blocks_cfg_q <= 11'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fmi_pkg::RegRowCount: row_count_q  <= cfg_data_i;
        fmi_pkg::RegStep:     step_q       <= cfg_data_i;
        fmi_pkg::RegBlocks:   blocks_cfg_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end
  assign blocks_q = {6'd0, blocks_cfg_q};

  logic [3:0]  st_q;
  fmi_pkg::req_t req_q;
  logic        active_q, empty_q;
  logic [1:0]  err_q;
  logic [16:0] lo_q, hi_q, nl_q;
  logic        side_q;  // 0 lower bound, 1 upper bound
  logic [16:0] pos_q, rem_q, quo_q, idx_q;
  logic [4:0]  dcnt_q;
  logic [17:0] cnt_q;
  logic        scan_v_q;
  fmi_pkg::rsp_t out_q;
  logic        out_v_q;

  logic [16:0] step_eff;
  assign step_eff = (step_q == '0) ? 17'd1 : step_q;

  // memories
  logic        bwt_we, ck_we, cum_we;
  logic [fmi_pkg::BwtAw-1:0] bwt_ra;
  logic [fmi_pkg::CkAw-1:0]  ck_ra;
  logic [fmi_pkg::CumAw-1:0] cum_ra;
  logic [8:0]  bwt_rd;
  logic [16:0] ck_rd, cum_rd;
  logic        acc;

  assign acc    = req.valid && req.ready;
  assign bwt_we = (st_q == StLoad) && (req_q.cmd == fmi_pkg::CmdLoadBwt)
                  && (req_q.addr < 19'(fmi_pkg::MaxRows));
  assign ck_we  = (st_q == StLoad) && (req_q.cmd == fmi_pkg::CmdLoadCkpt)
                  && (req_q.addr < 19'(fmi_pkg::CkptDepth));
  assign cum_we = (st_q == StLoad) && (req_q.cmd == fmi_pkg::CmdLoadCum)
                  && (req_q.addr < 19'(fmi_pkg::Alphabet));
  // block * 257 + symbol as shift and add
  assign ck_ra  = {1'b0, quo_q[9:0], 8'd0} + {9'd0, quo_q[9:0]}
                  + {11'd0, req_q.query_byte};
  assign cum_ra = {1'b0, req_q.query_byte};
  assign bwt_ra = idx_q[15:0];

  fmi_ram #(.Width(fmi_pkg::SymW), .Depth(fmi_pkg::MaxRows)) u_bwt (
    .clk_i, .we_i(bwt_we), .waddr_i(req_q.addr[15:0]), .wdata_i(req_q.load_value[8:0]),
    .raddr_i(bwt_ra), .rdata_o(bwt_rd));
  fmi_ram #(.Width(fmi_pkg::CntW), .Depth(fmi_pkg::CkptDepth)) u_ckpt (
    .clk_i, .we_i(ck_we), .waddr_i(req_q.addr), .wdata_i(req_q.load_value),
    .raddr_i(ck_ra), .rdata_o(ck_rd));
  fmi_ram #(.Width(fmi_pkg::CntW), .Depth(fmi_pkg::Alphabet)) u_cum (
    .clk_i, .we_i(cum_we), .waddr_i(req_q.addr[8:0]), .wdata_i(req_q.load_value),
    .raddr_i(cum_ra), .rdata_o(cum_rd));

  assign req.ready   = (st_q == StIdle);
  assign rsp.valid   = out_v_q;
  assign rsp.payload = out_q;

  // restoring division step
  logic [17:0] trial;
  assign trial = {rem_q, pos_q[16]} - {1'b0, step_eff};

  logic [16:0] pos_sel;
  assign pos_sel = side_q ? hi_q : lo_q;

  // block start is the bound minus its remainder
  logic [16:0] blk_start;
  assign blk_start = pos_sel - rem_q;

  // C[sym] + occ, saturated to 17 bits
  logic [18:0] sum;
  logic [16:0] new_b;
  assign sum   = {2'b00, cum_rd} + {1'b0, cnt_q};
  assign new_b = (sum[18:17] != 2'b00) ? 17'h1FFFF : sum[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      req_q    <= '0;
      active_q <= 1'b0;
      empty_q  <= 1'b0;
      err_q    <= fmi_pkg::ErrNone;
      lo_q     <= '0;
      hi_q     <= '0;
      nl_q     <= '0;
      side_q   <= 1'b0;
      pos_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      idx_q    <= '0;
      dcnt_q   <= '0;
      cnt_q    <= '0;
      scan_v_q <= 1'b0;
      out_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      unique case (st_q)
        StIdle: begin
          if (acc) begin
            req_q <= req.payload;
            if (req.payload.cmd == fmi_pkg::CmdQuery) begin
              // first byte opens the interval [0,row_count)
              if (!active_q) begin
                active_q <= 1'b1;
                lo_q     <= '0;
                hi_q     <= row_count_q;
                empty_q  <= 1'b0;
                err_q    <= fmi_pkg::ErrNone;
              end
              st_q <= StQuery;
            end else begin
              st_q <= StLoad;
            end
          end
        end
        StLoad: st_q <= StIdle;
        StQuery: begin
          side_q <= 1'b0;
          if (empty_q || err_q != fmi_pkg::ErrNone) st_q <= StFinish;
          else st_q <= StPos;
        end
        // range check on the bound, then start the division
        StPos: begin
          pos_q  <= pos_sel;
          rem_q  <= '0;
          quo_q  <= '0;
          dcnt_q <= '0;
          if (pos_sel > row_count_q || {1'b0, pos_sel} > 18'(fmi_pkg::MaxRows)) begin
            err_q <= fmi_pkg::ErrPos;
            st_q  <= StFinish;
          end else begin
            st_q <= StDiv;
          end
        end
        StDiv: begin
          dcnt_q <= dcnt_q + 5'd1;
          pos_q  <= {pos_q[15:0], 1'b0};
          if (!trial[17]) begin
            rem_q <= trial[16:0]; quo_q <= {quo_q[15:0], 1'b1};
          end else begin
            rem_q <= {rem_q[15:0], pos_q[16]}; quo_q <= {quo_q[15:0], 1'b0};
          end
          if (dcnt_q == 5'd16) st_q <= StChk;
        end
        StChk: begin
          idx_q <= blk_start;
          if (quo_q >= blocks_q || quo_q >= 17'(fmi_pkg::MaxBlocks)) begin
            err_q <= fmi_pkg::ErrBlock;
            st_q  <= StFinish;
          end else begin
            st_q <= StRd;
          end
        end
        StRd: begin
          cnt_q    <= {1'b0, ck_rd};
          scan_v_q <= 1'b0;
          st_q     <= StScan;
        end
        // one symbol read per cycle, data compared in the cycle after its read
        StScan: begin
          if (scan_v_q && bwt_rd == {1'b0, req_q.query_byte}) cnt_q <= cnt_q + 18'd1;
          if (idx_q < pos_sel) begin
            idx_q <= idx_q + 17'd1; scan_v_q <= 1'b1;
          end else begin
            scan_v_q <= 1'b0; st_q <= StSum;
          end
        end
        StSum: begin
          if (!side_q) begin
            nl_q   <= new_b;
            side_q <= 1'b1;
            st_q   <= StPos;
          end else begin
            lo_q <= nl_q;
            if (nl_q >= new_b) begin
              hi_q <= nl_q; empty_q <= 1'b1;
            end else begin
              hi_q <= new_b;
            end
            st_q <= StFinish;
          end
        end
        StFinish: begin
          if (req_q.last) begin
            active_q    <= 1'b0;
            out_v_q     <= 1'b1;
            out_q.error <= err_q;
            if (err_q != fmi_pkg::ErrNone) begin
              out_q.left <= '0; out_q.right <= '0; out_q.count <= '0;
            end else begin
              out_q.left <= lo_q; out_q.right <= hi_q; out_q.count <= hi_q - lo_q;
            end
            st_q <= StOut;
          end else begin
            st_q <= StIdle;
          end
        end
        StOut: begin
          if (rsp.ready) begin
            out_v_q <= 1'b0;
            st_q    <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result is only raised while the output stage holds it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (st_q == StOut)) else $error("result valid outside output state");
  // no new transaction while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready) else $error("accept while result pending");
  // an empty interval has equal bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_q && st_q == StIdle) |-> (lo_q == hi_q)) else $error("empty but bounds differ");
`endif
endmodule
